// ----- hw/rtl/cll_pkg.sv -----
package cll_pkg;

   localparam int NodeBits = 8;
   localparam int NodeCount = 256;

   typedef logic [NodeBits-1:0] node_type;

   // Command codes
   typedef enum logic [3:0] {
      ACT_INIT   = 4'd0,
      ACT_INS_BF = 4'd1,
      ACT_INS_FS = 4'd2,
      ACT_APPEND = 4'd3,
      ACT_POP_FS = 4'd4,
      ACT_POP_LS = 4'd5,
      ACT_EMPTY  = 4'd6,
      ACT_FIND   = 4'd7,
      ACT_REMOVE = 4'd8,
      ACT_LENGTH = 4'd9
   } action_type;

   // Which link memory a port touches
   typedef enum logic {
      LNK_NEXT  = 1'b0,
      LNK_PRIOR = 1'b1
   } link_sel_type;

   // Address source for the datapath
   typedef enum logic [2:0] {
      ADR_ANCHOR = 3'd0,
      ADR_ITEM   = 3'd1,
      ADR_TA     = 3'd2,
      ADR_TB     = 3'd3,
      ADR_CUR    = 3'd4
   } adr_sel_type;

   // Write data source
   typedef enum logic [1:0] {
      WD_ANCHOR = 2'd0,
      WD_ITEM   = 2'd1,
      WD_TA     = 2'd2,
      WD_TB     = 2'd3
   } wd_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD1,
      ST_RD2,
      ST_WR1,
      ST_WR2,
      ST_WR3,
      ST_WR4,
      ST_WALK,
      ST_CHK,
      ST_DONE
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic         load;
      logic         rd_en;
      link_sel_type rd_sel;
      adr_sel_type  rd_adr;
      logic         cap_ta;
      logic         cap_tb;
      logic         wr_en;
      link_sel_type wr_sel;
      adr_sel_type  wr_adr;
      wd_sel_type   wr_dat;
      logic         walk_start;
      logic         walk_step;
      logic         set_node_item;
      logic         set_node_ta;
      logic         set_valid;
      logic         rsp_load;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      action_type act;
      logic       rd_is_anchor;
      logic       walk_end;
   } stat_type;

endpackage

// ----- hw/rtl/cll_ctrl.sv -----
module cll_ctrl import cll_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_fire,
   input  logic     rsp_free,
   input  stat_type stat,
   output cmd_type  cmd,
   output logic     busy
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Sequencing of link reads and writes per command
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cmd.load = 1'b1;
               state_in = ST_RD1;
            end
         end
         ST_RD1: begin
            // first read: the anchor's or item's link
            cmd.rd_en = 1'b1;
            case (stat.act)
               ACT_INS_BF, ACT_APPEND, ACT_POP_LS: begin
                  cmd.rd_sel = LNK_PRIOR; cmd.rd_adr = ADR_ANCHOR;
               end
               ACT_REMOVE: begin
                  cmd.rd_sel = LNK_PRIOR; cmd.rd_adr = ADR_ITEM;
               end
               default: begin
                  cmd.rd_sel = LNK_NEXT; cmd.rd_adr = ADR_ANCHOR;
               end
            endcase
            state_in = ST_RD2;
         end
         ST_RD2: begin
            // read data of RD1 arrives here; capture into ta
            cmd.cap_ta = 1'b1;
            cmd.rd_en  = 1'b1;
            case (stat.act)
               ACT_POP_FS: begin
                  cmd.rd_sel = LNK_NEXT;  cmd.rd_adr = ADR_TA;
               end
               ACT_POP_LS: begin
                  cmd.rd_sel = LNK_PRIOR; cmd.rd_adr = ADR_TA;
               end
               ACT_REMOVE: begin
                  cmd.rd_sel = LNK_NEXT;  cmd.rd_adr = ADR_ITEM;
               end
               default: begin
                  cmd.rd_en = 1'b0;
               end
            endcase
            case (stat.act)
               ACT_INIT, ACT_INS_BF, ACT_INS_FS, ACT_APPEND, ACT_REMOVE:
                  state_in = ST_WR1;
               ACT_POP_FS, ACT_POP_LS: state_in = stat.rd_is_anchor ? ST_CHK : ST_WR1;
               ACT_FIND, ACT_LENGTH: begin
                  cmd.walk_start = 1'b1;
                  state_in = ST_WALK;
               end
               default: state_in = ST_CHK;
            endcase
         end
         ST_WR1: begin
            cmd.wr_en = 1'b1;
            case (stat.act)
               ACT_INIT: begin
                  cmd.wr_sel = LNK_NEXT; cmd.wr_adr = ADR_ANCHOR; cmd.wr_dat = WD_ANCHOR;
               end
               ACT_INS_BF, ACT_APPEND: begin
                  cmd.wr_sel = LNK_NEXT; cmd.wr_adr = ADR_ITEM; cmd.wr_dat = WD_ANCHOR;
               end
               ACT_INS_FS: begin
                  cmd.wr_sel = LNK_NEXT; cmd.wr_adr = ADR_ITEM; cmd.wr_dat = WD_TA;
               end
               ACT_POP_FS: begin
                  cmd.cap_tb = 1'b1;
                  cmd.wr_sel = LNK_NEXT; cmd.wr_adr = ADR_ANCHOR; cmd.wr_dat = WD_TB;
               end
               ACT_POP_LS: begin
                  cmd.cap_tb = 1'b1;
                  cmd.wr_sel = LNK_NEXT; cmd.wr_adr = ADR_TB; cmd.wr_dat = WD_ANCHOR;
               end
               default: begin
                  // remove: tb = next[n]; next[ta] = tb
                  cmd.cap_tb = 1'b1;
                  cmd.wr_sel = LNK_NEXT; cmd.wr_adr = ADR_TA; cmd.wr_dat = WD_TB;
               end
            endcase
            state_in = ST_WR2;
         end
         ST_WR2: begin
            cmd.wr_en = 1'b1;
            state_in  = ST_WR3;
            case (stat.act)
               ACT_INIT: begin
                  cmd.wr_sel = LNK_PRIOR; cmd.wr_adr = ADR_ANCHOR; cmd.wr_dat = WD_ANCHOR;
                  state_in = ST_CHK;
               end
               ACT_INS_BF, ACT_APPEND: begin
                  cmd.wr_sel = LNK_PRIOR; cmd.wr_adr = ADR_ITEM; cmd.wr_dat = WD_TA;
               end
               ACT_INS_FS: begin
                  cmd.wr_sel = LNK_PRIOR; cmd.wr_adr = ADR_ITEM; cmd.wr_dat = WD_ANCHOR;
               end
               ACT_POP_FS: begin
                  cmd.wr_sel = LNK_PRIOR; cmd.wr_adr = ADR_TB; cmd.wr_dat = WD_ANCHOR;
                  cmd.set_node_ta = 1'b1; cmd.set_valid = 1'b1;
                  state_in = ST_CHK;
               end
               ACT_POP_LS: begin
                  cmd.wr_sel = LNK_PRIOR; cmd.wr_adr = ADR_ANCHOR; cmd.wr_dat = WD_TB;
                  cmd.set_node_ta = 1'b1; cmd.set_valid = 1'b1;
                  state_in = ST_CHK;
               end
               default: begin
                  cmd.wr_sel = LNK_PRIOR; cmd.wr_adr = ADR_TB; cmd.wr_dat = WD_TA;
                  cmd.set_node_item = 1'b1;
                  state_in = ST_CHK;
               end
            endcase
         end
         ST_WR3: begin
            cmd.wr_en = 1'b1;
            if (stat.act == ACT_INS_FS) begin
               cmd.wr_sel = LNK_PRIOR; cmd.wr_adr = ADR_TA; cmd.wr_dat = WD_ITEM;
            end else begin
               cmd.wr_sel = LNK_NEXT; cmd.wr_adr = ADR_TA; cmd.wr_dat = WD_ITEM;
            end
            state_in = ST_WR4;
         end
         ST_WR4: begin
            cmd.wr_en = 1'b1;
            if (stat.act == ACT_INS_FS) begin
               cmd.wr_sel = LNK_NEXT; cmd.wr_adr = ADR_ANCHOR; cmd.wr_dat = WD_ITEM;
            end else begin
               cmd.wr_sel = LNK_PRIOR; cmd.wr_adr = ADR_ANCHOR; cmd.wr_dat = WD_ITEM;
            end
            state_in = ST_CHK;
         end
         ST_WALK: begin
            // one next-link read per cycle along the list
            cmd.rd_en = 1'b1; cmd.rd_sel = LNK_NEXT; cmd.rd_adr = ADR_CUR;
            cmd.walk_step = 1'b1;
            if (stat.walk_end) begin
               state_in = ST_CHK;
            end
         end
         ST_CHK: begin
            // read anchor's next link after all updates
            cmd.rd_en = 1'b1; cmd.rd_sel = LNK_NEXT; cmd.rd_adr = ADR_ANCHOR;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ----- hw/rtl/cll_dpath.sv -----
module cll_dpath import cll_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   input  logic [3:0] req_action,
   input  node_type   req_anchor,
   input  node_type   req_item,
   input  logic       rsp_take,
   output stat_type   stat,
   output logic       rsp_full,
   output node_type   rsp_node,
   output logic       rsp_ok,
   output node_type   rsp_count,
   output logic       rsp_empty
);

   logic [NodeBits-1:0] next_mem  [NodeCount];
   logic [NodeBits-1:0] prior_mem [NodeCount];

   logic [3:0]  act_ff;
   node_type    anc_ff, itm_ff, ta_ff, tb_ff, rd_ff, cur_ff;
   node_type    node_ff, cnt_ff;
   logic        valid_ff, found_ff;
   logic [NodeBits:0] steps_ff;
   logic        full_ff;
   node_type    rd_adr, wr_adr, wr_dat, rd_val;
   logic        walking_ff;

   function automatic node_type pick(adr_sel_type s, node_type a, node_type i,
                                     node_type x, node_type y, node_type c);
      node_type r;
      case (s)
         ADR_ANCHOR: r = a;
         ADR_ITEM:   r = i;
         ADR_TA:     r = x;
         ADR_TB:     r = y;
         default:    r = c;
      endcase
      return r;
   endfunction

   assign rd_val = rd_ff;

   // Address and data selection
   always_comb begin
      rd_adr = pick(cmd.rd_adr, anc_ff, itm_ff, cmd.cap_ta ? rd_val : ta_ff,
                    tb_ff, walking_ff ? rd_val : cur_ff);
      wr_adr = pick(cmd.wr_adr, anc_ff, itm_ff, ta_ff, cmd.cap_tb ? rd_val : tb_ff,
                    cur_ff);
      case (cmd.wr_dat)
         WD_ANCHOR: wr_dat = anc_ff;
         WD_ITEM:   wr_dat = itm_ff;
         WD_TA:     wr_dat = ta_ff;
         default:   wr_dat = cmd.cap_tb ? rd_val : tb_ff;
      endcase
   end

   // Link memories: one read and one write port each
   always_ff @(posedge clock) begin
      if (cmd.wr_en && cmd.wr_sel == LNK_NEXT) begin
         next_mem[wr_adr] <= wr_dat;
      end
      if (cmd.wr_en && cmd.wr_sel == LNK_PRIOR) begin
         prior_mem[wr_adr] <= wr_dat;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_ff <= (cmd.rd_sel == LNK_NEXT) ? next_mem[rd_adr] : prior_mem[rd_adr];
      end
   end

   // Operand and scratch registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff <= req_action;
         anc_ff <= req_anchor;
         itm_ff <= req_item;
      end
      if (cmd.cap_ta) begin
         ta_ff <= rd_val;
      end
      if (cmd.cap_tb) begin
         tb_ff <= rd_val;
      end
   end

   // Walk: cur is the node just read back; steps counts nodes passed
   logic walk_hit;
   assign walk_hit = walking_ff && ((rd_val == anc_ff) || steps_ff[NodeBits]);

   always_ff @(posedge clock) begin
      if (reset) begin
         walking_ff <= 1'b0;
      end else if (cmd.walk_start) begin
         walking_ff <= 1'b1;
      end else if (walk_hit) begin
         walking_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         node_ff  <= '0;
         valid_ff <= 1'b0;
         cnt_ff   <= '0;
         found_ff <= 1'b0;
      end else if (cmd.set_node_item) begin
         node_ff <= itm_ff;
      end else if (cmd.set_node_ta) begin
         node_ff  <= ta_ff;
         valid_ff <= cmd.set_valid;
      end
      if (cmd.walk_start) begin
         steps_ff <= '0;
      end else if (walking_ff && !walk_hit) begin
         cur_ff   <= rd_val;
         steps_ff <= steps_ff + 1'b1;
         if (act_ff == ACT_FIND && !found_ff && rd_val == itm_ff) begin
            found_ff <= 1'b1;
            valid_ff <= 1'b1;
            cnt_ff   <= steps_ff[NodeBits-1:0];
         end
      end else if (walk_hit && act_ff == ACT_LENGTH) begin
         cnt_ff <= steps_ff[NodeBits] ? '1 : steps_ff[NodeBits-1:0];
      end
   end

   // Output register, freed when the result transfer completes
   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         full_ff <= 1'b1;
      end else if (rsp_take) begin
         full_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_node  <= node_ff;
         rsp_ok    <= valid_ff;
         rsp_count <= cnt_ff;
         rsp_empty <= (rd_val == anc_ff);
      end
   end

   assign rsp_full          = full_ff;
   assign stat.act          = action_type'(act_ff);
   assign stat.rd_is_anchor = (rd_val == anc_ff);
   assign stat.walk_end     = walk_hit;

endmodule

// ----- hw/rtl/circular_linked_list_engine.sv -----
// Channel | Ports          | Contents (low bit first)
// request | req_t*         | tdata: action[3:0] anchor_node[11:4] item_node[19:12]
// result  | rsp_t*         | tdata: result_node[7:0] result_valid[8] result_count[16:9]
//         |                |        list_is_empty[17]
// One command at a time. An empty test or a pop of an empty list writes no links, init,
// pops and remove write two links, inserts write four, and find and length walk the list
// (at most 256 nodes), one next-link read per node.
// The engine returns to idle after each command before the next request transfer. The result
// sits in an output register, so a stalled result blocks only the following command.
// Reset is synchronous; the link memories are not cleared.
module circular_linked_list_engine import cll_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // action, anchor_node, item_node
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // result_node, result_valid, result_count, list_is_empty
);

   cmd_type  cmd;
   stat_type stat;
   logic     busy, full;
   node_type r_node, r_count;
   logic     r_ok, r_empty;
   logic     req_fire, rsp_fire;

   assign req_tready = !busy;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;

   cll_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_fire (req_fire),
      .rsp_free (!full || rsp_tready),
      .stat     (stat),
      .cmd      (cmd),
      .busy     (busy)
   );

   cll_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_action (req_tdata[3:0]),
      .req_anchor (req_tdata[11:4]),
      .req_item   (req_tdata[19:12]),
      .rsp_take   (rsp_fire),
      .stat       (stat),
      .rsp_full   (full),
      .rsp_node   (r_node),
      .rsp_ok     (r_ok),
      .rsp_count  (r_count),
      .rsp_empty  (r_empty)
   );

   assign rsp_tvalid = full;
   assign rsp_tdata  = {6'd0, r_empty, r_count, r_ok, r_node};

   // No new command starts while one is in flight
   assert property (@(posedge clock) disable iff (reset) busy |-> !req_fire)
      else $error("command accepted while busy");
   // A result is loaded only when the output register can take it
   assert property (@(posedge clock) disable iff (reset) cmd.rsp_load |-> (!full || rsp_tready))
      else $error("result overwritten");
   // A command always leaves the idle state the next cycle
   assert property (@(posedge clock) disable iff (reset) req_fire |=> busy)
      else $error("accepted command lost");

endmodule

// ----- sim/circular_linked_list_engine_tb.sv -----
`timescale 1ns / 1ps

module circular_linked_list_engine_tb;
   import cll_pkg::*;

   // One expected result transfer
   typedef struct packed {
      node_type   node;
      logic       valid;
      logic [7:0] count;
      logic       empty;
   } list_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // action[3:0] anchor_node[11:4] item_node[19:12]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // result_node[7:0] result_valid[8] result_count[16:9]
                                  // list_is_empty[17]

   circular_linked_list_engine u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #4 clock = ~clock;

   // Shadow link memories
   node_type next_shadow [NodeCount];
   node_type prior_shadow [NodeCount];

   logic [23:0]     pending_cmds [$];
   list_result_type expected_results [$];
   int              mismatch_count = 0;
   int              result_count_seen = 0;
   int              cmds_sent = 0;
   int              total_cmds = 0;
   int              send_idle_pct = 28;
   int              recv_idle_pct = 48;
   logic            req_fire = 1'b0;
   longint          cycle_count = 0;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH result %0d: %s got %0d expected %0d",
               result_count_seen, what, got, want);
      mismatch_count++;
   endtask

   // Walk from head; returns steps back to head, or NodeCount on a broken list
   function automatic int walk_list(input node_type head, input node_type target,
                                    output int pos);
      node_type cur;
      int       steps;
      cur = next_shadow[head];
      pos = -1;
      for (steps = 0; steps < NodeCount; steps++) begin
         if (cur == head) return steps;
         if (pos < 0 && cur == target) pos = steps;
         cur = next_shadow[cur];
      end
      return NodeCount;
   endfunction

   // Apply one command to the shadow lists and return what the block must answer
   function automatic list_result_type apply_command(input logic [23:0] cmd);
      logic [3:0]      act;
      node_type        a, n, t;
      int              pos, len;
      list_result_type r;
      act = cmd[3:0];
      a = cmd[11:4];
      n = cmd[19:12];
      r = '0;
      case (act)
         ACT_INIT: begin
            next_shadow[a] = a;
            prior_shadow[a] = a;
         end
         ACT_INS_BF: begin
            next_shadow[n] = a;
            prior_shadow[n] = prior_shadow[a];
            next_shadow[prior_shadow[a]] = n;
            prior_shadow[a] = n;
         end
         ACT_INS_FS: begin
            next_shadow[n] = next_shadow[a];
            prior_shadow[n] = a;
            prior_shadow[next_shadow[a]] = n;
            next_shadow[a] = n;
         end
         ACT_APPEND: begin
            prior_shadow[n] = prior_shadow[a];
            next_shadow[n] = a;
            next_shadow[prior_shadow[a]] = n;
            prior_shadow[a] = n;
         end
         ACT_POP_FS: begin
            if (next_shadow[a] != a) begin
               t = next_shadow[a];
               next_shadow[a] = next_shadow[t];
               prior_shadow[next_shadow[t]] = a;
               r.node = t;
               r.valid = 1'b1;
            end
         end
         ACT_POP_LS: begin
            if (prior_shadow[a] != a) begin
               t = prior_shadow[a];
               next_shadow[prior_shadow[t]] = a;
               prior_shadow[a] = prior_shadow[t];
               r.node = t;
               r.valid = 1'b1;
            end
         end
         ACT_FIND: begin
            void'(walk_list(a, n, pos));
            if (pos >= 0) begin
               r.valid = 1'b1;
               r.count = (pos > 255) ? 8'd255 : pos[7:0];
            end
         end
         ACT_REMOVE: begin
            next_shadow[prior_shadow[n]] = next_shadow[n];
            prior_shadow[next_shadow[n]] = prior_shadow[n];
            r.node = n;
         end
         ACT_LENGTH: begin
            len = walk_list(a, '0, pos);
            r.count = (len > 255) ? 8'd255 : len[7:0];
         end
         default: ;
      endcase
      r.empty = (next_shadow[a] == a);
      return r;
   endfunction

   function automatic logic [23:0] pack_cmd(input logic [3:0] act, input node_type a,
                                            input node_type n);
      return {4'b0, n, a, act};
   endfunction

   // Predict on request transfers, check on result transfers
   always @(posedge clock) begin
      list_result_type got, want;
      req_fire <= req_tvalid && req_tready;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[7:0], rsp_tdata[8], rsp_tdata[16:9], rsp_tdata[17]};
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result transfer", 1, 0);
            end else begin
               want = expected_results.pop_front();
               if (got.node != want.node)
                  report_mismatch("result_node", int'(got.node), int'(want.node));
               if (got.valid != want.valid)
                  report_mismatch("result_valid", int'(got.valid), int'(want.valid));
               if (got.count != want.count)
                  report_mismatch("result_count", int'(got.count), int'(want.count));
               if (got.empty != want.empty)
                  report_mismatch("list_is_empty", int'(got.empty), int'(want.empty));
            end
            result_count_seen++;
         end
         if (req_tvalid && req_tready)
            expected_results.push_back(apply_command(req_tdata));
      end
   end

   // Command driver and result back-pressure, both at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         if (req_fire || !req_tvalid) begin
            if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tdata <= pending_cmds.pop_front();
               req_tvalid <= 1'b1;
               cmds_sent++;
               // idle profile follows progress through the run
               if (cmds_sent > (2 * total_cmds) / 3) begin
                  send_idle_pct = 0;
                  recv_idle_pct = 0;
               end else if (cmds_sent > total_cmds / 3) begin
                  send_idle_pct = 48;
                  recv_idle_pct = 28;
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 3000000) begin
         $display("timeout with %0d results outstanding", expected_results.size());
         $display("circular_linked_list_engine_tb: done, errors");
         $finish;
      end
   end

   initial begin
      int          i, k;
      logic [3:0]  act;
      node_type    a, n;
      // Every link gets written first, so no walk ever reads an unwritten entry
      for (i = 0; i < NodeCount; i++)
         pending_cmds.push_back(pack_cmd(ACT_INIT, i[7:0], 8'd0));

      // Directed: empty heads, basic edits, aliases, broken walk, unused codes
      pending_cmds.push_back(pack_cmd(ACT_EMPTY, 8'd0, 8'd0));
      pending_cmds.push_back(pack_cmd(ACT_POP_FS, 8'd0, 8'd0));
      pending_cmds.push_back(pack_cmd(ACT_POP_LS, 8'd0, 8'd0));
      pending_cmds.push_back(pack_cmd(ACT_FIND, 8'd0, 8'd0));
      pending_cmds.push_back(pack_cmd(ACT_APPEND, 8'd0, 8'd1));
      pending_cmds.push_back(pack_cmd(ACT_INS_FS, 8'd0, 8'd2));
      pending_cmds.push_back(pack_cmd(ACT_INS_BF, 8'd1, 8'd255));
      pending_cmds.push_back(pack_cmd(ACT_LENGTH, 8'd0, 8'd0));
      pending_cmds.push_back(pack_cmd(ACT_FIND, 8'd0, 8'd255));
      pending_cmds.push_back(pack_cmd(ACT_FIND, 8'd0, 8'd77));
      pending_cmds.push_back(pack_cmd(ACT_FIND, 8'd0, 8'd0));
      pending_cmds.push_back(pack_cmd(ACT_REMOVE, 8'd0, 8'd255));
      pending_cmds.push_back(pack_cmd(ACT_POP_FS, 8'd0, 8'd0));
      pending_cmds.push_back(pack_cmd(ACT_POP_LS, 8'd0, 8'd0));
      pending_cmds.push_back(pack_cmd(ACT_LENGTH, 8'd0, 8'd0));
      pending_cmds.push_back(pack_cmd(ACT_APPEND, 8'd255, 8'd255));
      // node in a list re-initialized: walk from 0 never returns
      pending_cmds.push_back(pack_cmd(ACT_APPEND, 8'd0, 8'd3));
      pending_cmds.push_back(pack_cmd(ACT_INIT, 8'd3, 8'd0));
      pending_cmds.push_back(pack_cmd(ACT_LENGTH, 8'd0, 8'd0));
      pending_cmds.push_back(pack_cmd(ACT_FIND, 8'd0, 8'd200));
      for (i = 10; i < 16; i++) pending_cmds.push_back(pack_cmd(i[3:0], 8'd0, 8'd255));
      pending_cmds.push_back(pack_cmd(ACT_INIT, 8'd0, 8'd0));
      pending_cmds.push_back(pack_cmd(ACT_INIT, 8'd3, 8'd0));

      // Random: mostly list traffic on a few heads, some raw noise
      for (i = 0; i < 720; i++) begin
         k = $urandom_range(99);
         if (k < 85) begin
            a = node_type'($urandom_range(7));
            n = node_type'($urandom_range(255, 8));
            case ($urandom_range(19))
               0:            act = ACT_INIT;
               1, 2:         act = ACT_INS_BF;
               3, 4, 5:      act = ACT_INS_FS;
               6, 7, 8:      act = ACT_APPEND;
               9, 10:        act = ACT_POP_FS;
               11, 12:       act = ACT_POP_LS;
               13:           act = ACT_EMPTY;
               14, 15:       act = ACT_FIND;
               16, 17:       act = ACT_REMOVE;
               default:      act = ACT_LENGTH;
            endcase
            if (act == ACT_INS_BF && $urandom_range(1)) a = node_type'($urandom_range(255));
         end else begin
            act = 4'($urandom_range(15));
            a = node_type'($urandom_range(255));
            n = node_type'($urandom_range(255));
         end
         pending_cmds.push_back(pack_cmd(act, a, n));
      end
      total_cmds = pending_cmds.size();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      wait (pending_cmds.size() == 0);
      @(posedge clock);
      while (req_tvalid || expected_results.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);

      $display("covered %0d commands (node pool seeded, directed cases, random list traffic)",
               total_cmds);
      $display("checked %0d results under three back-pressure profiles", result_count_seen);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("circular_linked_list_engine_tb: done, clean");
      end else begin
         $display("circular_linked_list_engine_tb: done, errors");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/cll_pkg.sv
hw/rtl/cll_ctrl.sv
hw/rtl/cll_dpath.sv
hw/rtl/circular_linked_list_engine.sv
sim/circular_linked_list_engine_tb.sv
